/* rtl/rrfa_pkg.sv */
// ----------------------------------------------------------------------------
// rrfa_pkg
// Shared types and constants for the round robin frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package rrfa_pkg;

	localparam int NUM_HOSTS_DEF     = 16;
	localparam int ALLOC_ENTRIES_DEF = 16;
	localparam int PB_RESET          = 4;
	localparam int FRAMES_MAX        = 1023;

	typedef enum logic [1:0] {
		CMD_CLR_REQ   = 2'd0,
		CMD_ADD       = 2'd1,
		CMD_ALLOC     = 2'd2,
		CMD_CLR_ALLOC = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] pid;
		logic [7:0] request_frames;
		logic       placement_upper;
		logic [9:0] slot_budget;
	} in_beat_t;

	typedef struct packed {
		logic        entry_valid;
		logic [3:0]  entry_index;
		logic [7:0]  entry_pid;
		logic [9:0]  entry_frames;
		logic [3:0]  piggyback_count;
		logic [12:0] total_requested;
		logic [9:0]  total_allocated;
		logic        requests_pending;
		logic        last;
	} out_beat_t;

	// request table word
	typedef struct packed {
		logic [7:0] pid;
		logic [7:0] remaining;
		logic [7:0] size;
	} req_word_t;

	// allocation table word
	typedef struct packed {
		logic [7:0] pid;
		logic [9:0] frames;
	} alloc_word_t;

endpackage
`default_nettype wire

/* rtl/rrfa_ram.sv */
// ----------------------------------------------------------------------------
// rrfa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module rrfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/rrfa_ctrl.sv */
// ----------------------------------------------------------------------------
// rrfa_ctrl
// Command sequencer: table updates, round robin grant loop, piggyback pass
// and allocation list output.
// ----------------------------------------------------------------------------
`default_nettype none
module rrfa_ctrl import rrfa_pkg::*; #(
	parameter int NUM_HOSTS     = NUM_HOSTS_DEF,
	parameter int ALLOC_ENTRIES = ALLOC_ENTRIES_DEF,
	localparam int SLOTS = NUM_HOSTS + 1,
	localparam int SW = $clog2(SLOTS),
	localparam int AW = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_beat_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_beat_t        out_data,
	input  wire logic [3:0]  max_pb,
	output logic             req_we,
	output logic [SW-1:0]    req_waddr,
	output req_word_t        req_wdata,
	output logic [SW-1:0]    req_raddr,
	input  wire req_word_t   req_rdata,
	output logic             alc_we,
	output logic [AW-1:0]    alc_waddr,
	output alloc_word_t      alc_wdata,
	output logic [AW-1:0]    alc_raddr,
	input  wire alloc_word_t alc_rdata
);

	typedef enum logic [4:0] {
		S_IDLE, S_STAT, S_RSUM_RD, S_RSUM_DO, S_SEL, S_GRD, S_GDO, S_SRD, S_SDO,
		S_ARD, S_ADO, S_GWR, S_PRD, S_PDO, S_PDIV, S_PNX, S_ERD, S_EWR
	} state_t;

	localparam logic [SW-1:0] LAST_SLOT  = SW'(NUM_HOSTS);
	localparam logic [AW-1:0] LAST_ENTRY = AW'(ALLOC_ENTRIES - 1);

	state_t            state_q;
	logic [SW-1:0]     r_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     k_q;
	logic [SLOTS-1:0]  req_valid_q;
	logic [SLOTS-1:0]  pend_q;
	logic [SLOTS-1:0]  map_valid_q;
	logic [AW-1:0]     map_idx_q [SLOTS];
	logic [ALLOC_ENTRIES-1:0] alc_valid_q;
	logic [3:0]        pb_q [ALLOC_ENTRIES];
	logic [9:0]        budget_q;
	logic [SW-1:0]     up_q;
	logic [SW-1:0]     lo_q;
	logic [12:0]       rsum_q;
	logic [9:0]        asum_q;
	logic [13:0]       acc_q;
	logic [7:0]        cur_pid_q;
	logic [7:0]        cur_rem_q;
	logic [7:0]        cur_size_q;
	logic [9:0]        fr_q;
	logic [9:0]        div_rem_q;
	logic [3:0]        div_cnt_q;
	logic [3:0]        stat_idx_q;
	logic              out_valid_q;
	out_beat_t         out_q;

	logic              in_acc;
	logic              out_free;
	logic              out_load;
	logic [SW-1:0]     slot;
	logic              free_found;
	logic [AW-1:0]     free_idx;
	logic              in_range;
	logic [SW-1:0]     slot_i;
	logic [9:0]        fr_inc;
	logic [3:0]        stat_pb;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && (state_q == S_STAT || state_q == S_EWR);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign slot     = in_data.placement_upper ? up_q : lo_q;
	assign in_range = (int'(i_q) <= NUM_HOSTS);
	assign slot_i   = SW'(i_q);
	assign fr_inc   = (fr_q == 10'(FRAMES_MAX)) ? fr_q : fr_q + 10'd1;
	assign stat_pb  = (int'(stat_idx_q) < ALLOC_ENTRIES) ? pb_q[AW'(stat_idx_q)] : 4'd0;

	// lowest free allocation entry
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int e = ALLOC_ENTRIES - 1; e >= 0; e--) begin
			if (!alc_valid_q[e]) begin
				free_found = 1'b1;
				free_idx   = AW'(e);
			end
		end
	end

	always_comb begin
		req_raddr = (state_q == S_PRD || state_q == S_PDO) ? slot_i : r_q;
		alc_raddr = (state_q == S_ARD || state_q == S_ADO) ? k_q : i_q;
		req_we    = 1'b0;
		req_waddr = r_q;
		req_wdata = '{pid: cur_pid_q, remaining: cur_rem_q - 8'd1, size: cur_size_q};
		alc_we    = (state_q == S_GWR);
		alc_waddr = k_q;
		alc_wdata = '{pid: cur_pid_q, frames: fr_inc};
		if (state_q == S_GWR) begin
			req_we = 1'b1;
		end else if (in_acc && in_data.command == CMD_ADD) begin
			req_we    = 1'b1;
			req_waddr = slot;
			req_wdata = '{pid: in_data.pid, remaining: in_data.request_frames,
				size: in_data.request_frames};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			r_q         <= '0;
			i_q         <= '0;
			k_q         <= '0;
			req_valid_q <= '0;
			pend_q      <= '0;
			map_valid_q <= '0;
			for (int s = 0; s < SLOTS; s++) map_idx_q[s] <= '0;
			alc_valid_q <= '0;
			for (int e = 0; e < ALLOC_ENTRIES; e++) pb_q[e] <= '0;
			budget_q    <= '0;
			up_q        <= SW'(NUM_HOSTS / 2 + 1);
			lo_q        <= SW'(NUM_HOSTS / 2);
			rsum_q      <= '0;
			asum_q      <= '0;
			acc_q       <= '0;
			cur_pid_q   <= '0;
			cur_rem_q   <= '0;
			cur_size_q  <= '0;
			fr_q        <= '0;
			div_rem_q   <= '0;
			div_cnt_q   <= '0;
			stat_idx_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (!out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						stat_idx_q <= (in_data.command == CMD_ADD) ? 4'(slot) : '0;
						unique case (in_data.command)
							CMD_CLR_REQ: begin
								req_valid_q <= '0;
								pend_q      <= '0;
								budget_q    <= in_data.slot_budget;
								up_q        <= SW'(NUM_HOSTS / 2 + 1);
								lo_q        <= SW'(NUM_HOSTS / 2);
								state_q     <= S_STAT;
							end
							CMD_ADD: begin
								req_valid_q[slot] <= 1'b1;
								pend_q[slot]      <= (in_data.request_frames != 8'd0);
								if (in_data.placement_upper) begin
									up_q <= (slot == LAST_SLOT) ? '0 : slot + SW'(1);
								end else begin
									lo_q <= (slot == '0) ? LAST_SLOT : slot - SW'(1);
								end
								state_q    <= S_STAT;
							end
							CMD_ALLOC: begin
								rsum_q      <= '0;
								r_q         <= '0;
								map_valid_q <= '0;
								state_q     <= S_RSUM_RD;
							end
							CMD_CLR_ALLOC: begin
								alc_valid_q <= '0;
								state_q     <= S_STAT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_STAT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q <= '{entry_valid: 1'b0, entry_index: stat_idx_q,
							entry_pid: '0, entry_frames: '0, piggyback_count: stat_pb,
							total_requested: rsum_q, total_allocated: asum_q,
							requests_pending: |pend_q, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_RSUM_RD: state_q <= S_RSUM_DO;
				S_RSUM_DO: begin
					if (req_valid_q[r_q]) begin
						rsum_q <= rsum_q + 13'(req_rdata.remaining);
					end
					if (r_q == LAST_SLOT) begin
						r_q     <= '0;
						state_q <= S_SEL;
					end else begin
						r_q     <= r_q + SW'(1);
						state_q <= S_RSUM_RD;
					end
				end
				S_SEL: begin
					if (budget_q == '0 || pend_q == '0) begin
						i_q     <= '0;
						acc_q   <= '0;
						state_q <= S_PRD;
					end else if (pend_q[r_q]) begin
						state_q <= S_GRD;
					end else begin
						r_q <= (r_q == LAST_SLOT) ? '0 : r_q + SW'(1);
					end
				end
				S_GRD: state_q <= S_GDO;
				S_GDO: begin
					cur_pid_q  <= req_rdata.pid;
					cur_rem_q  <= req_rdata.remaining;
					cur_size_q <= req_rdata.size;
					if (map_valid_q[r_q]) begin
						k_q     <= map_idx_q[r_q];
						state_q <= S_ARD;
					end else begin
						i_q     <= '0;
						state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SDO;
				S_SDO: begin
					if (alc_valid_q[i_q] && alc_rdata.pid == cur_pid_q) begin
						k_q              <= i_q;
						fr_q             <= alc_rdata.frames;
						map_valid_q[r_q] <= 1'b1;
						map_idx_q[r_q]   <= i_q;
						state_q          <= S_GWR;
					end else if (i_q == LAST_ENTRY) begin
						if (free_found) begin
							k_q                   <= free_idx;
							fr_q                  <= '0;
							alc_valid_q[free_idx] <= 1'b1;
							map_valid_q[r_q]      <= 1'b1;
							map_idx_q[r_q]        <= free_idx;
							state_q               <= S_GWR;
						end else begin
							// table full: allocation ends here
							i_q     <= '0;
							acc_q   <= '0;
							state_q <= S_PRD;
						end
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= S_SRD;
					end
				end
				S_ARD: state_q <= S_ADO;
				S_ADO: begin
					fr_q    <= alc_rdata.frames;
					state_q <= S_GWR;
				end
				S_GWR: begin
					pend_q[r_q] <= (cur_rem_q != 8'd1);
					budget_q    <= budget_q - 10'd1;
					r_q         <= (r_q == LAST_SLOT) ? '0 : r_q + SW'(1);
					state_q     <= S_SEL;
				end
				S_PRD: state_q <= S_PDO;
				S_PDO: begin
					state_q <= S_PNX;
					if (alc_valid_q[i_q]) begin
						acc_q <= acc_q + 14'(alc_rdata.frames);
						if (in_range && req_valid_q[slot_i] && req_rdata.size != 8'd0 &&
							alc_rdata.frames > 10'(req_rdata.size)) begin
							div_rem_q  <= alc_rdata.frames;
							div_cnt_q  <= '0;
							cur_size_q <= req_rdata.size;
							state_q    <= S_PDIV;
						end
					end
				end
				S_PDIV: begin
					// ceiling quotient by repeated subtraction, capped at the clip
					if (div_rem_q == '0 || div_cnt_q == max_pb) begin
						pb_q[i_q] <= div_cnt_q;
						state_q   <= S_PNX;
					end else begin
						div_rem_q <= (div_rem_q > 10'(cur_size_q)) ?
							div_rem_q - 10'(cur_size_q) : '0;
						div_cnt_q <= div_cnt_q + 4'd1;
					end
				end
				S_PNX: begin
					if (i_q == LAST_ENTRY) begin
						asum_q  <= (acc_q > 14'(FRAMES_MAX)) ? 10'(FRAMES_MAX) : acc_q[9:0];
						i_q     <= '0;
						state_q <= S_ERD;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= S_PRD;
					end
				end
				S_ERD: state_q <= S_EWR;
				S_EWR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q <= '{entry_valid: alc_valid_q[i_q], entry_index: 4'(i_q),
							entry_pid: alc_valid_q[i_q] ? alc_rdata.pid : 8'd0,
							entry_frames: alc_valid_q[i_q] ? alc_rdata.frames : 10'd0,
							piggyback_count: pb_q[i_q], total_requested: rsum_q,
							total_allocated: asum_q, requests_pending: |pend_q,
							last: (i_q == LAST_ENTRY)};
						if (i_q == LAST_ENTRY) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/round_robin_frame_allocator_unit.sv */
// Status commands (clear requests, add, clear allocations): one beat from S_STAT after accept,
// sent once the output is free. Allocate: demand totalling over all NUM_HOSTS+1 request slots,
// then the round robin grant loop (allocation entries scanned on a request's first grant, idle
// slots passed over), then the piggyback pass over every entry and one output beat per entry.
// One item at a time; the grant loop is paced by the single read port of each table RAM.
// Reset clears the control registers and valid bits, not the table RAMs; no clearing pass, the block accepts at once.
// ----------------------------------------------------------------------------
// round_robin_frame_allocator_unit
// TDMA slot scheduler with request and allocation tables held in RAM.
// ----------------------------------------------------------------------------
`default_nettype none
module round_robin_frame_allocator_unit import rrfa_pkg::*; #(
	parameter int NUM_HOSTS     = NUM_HOSTS_DEF,
	parameter int ALLOC_ENTRIES = ALLOC_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_beat_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_beat_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int SLOTS = NUM_HOSTS + 1;
	localparam int SW = $clog2(SLOTS);
	localparam int AW = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;

	logic [3:0]    max_pb_q;
	logic          req_we;
	logic [SW-1:0] req_waddr;
	logic [SW-1:0] req_raddr;
	req_word_t     req_wdata;
	req_word_t     req_rdata;
	logic          alc_we;
	logic [AW-1:0] alc_waddr;
	logic [AW-1:0] alc_raddr;
	alloc_word_t   alc_wdata;
	alloc_word_t   alc_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {28'd0, max_pb_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pb_q <= 4'(PB_RESET);
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			max_pb_q <= pwdata[3:0];
		end
	end

	rrfa_ram #(.WIDTH($bits(req_word_t)), .DEPTH(SLOTS)) u_req_ram (
		.clk   (clk),
		.we    (req_we),
		.waddr (req_waddr),
		.wdata (req_wdata),
		.raddr (req_raddr),
		.rdata (req_rdata)
	);

	rrfa_ram #(.WIDTH($bits(alloc_word_t)), .DEPTH(ALLOC_ENTRIES)) u_alc_ram (
		.clk   (clk),
		.we    (alc_we),
		.waddr (alc_waddr),
		.wdata (alc_wdata),
		.raddr (alc_raddr),
		.rdata (alc_rdata)
	);

	rrfa_ctrl #(.NUM_HOSTS(NUM_HOSTS), .ALLOC_ENTRIES(ALLOC_ENTRIES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.max_pb    (max_pb_q),
		.req_we    (req_we),
		.req_waddr (req_waddr),
		.req_wdata (req_wdata),
		.req_raddr (req_raddr),
		.req_rdata (req_rdata),
		.alc_we    (alc_we),
		.alc_waddr (alc_waddr),
		.alc_wdata (alc_wdata),
		.alc_raddr (alc_raddr),
		.alc_rdata (alc_rdata)
	);

endmodule
`default_nettype wire

/* rtl/rrfa_chk.sv */
// ----------------------------------------------------------------------------
// rrfa_chk
// Port-level checks for the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rrfa_chk import rrfa_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_beat_t out_data
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed under stall");

	// one command in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a command was in progress");

	a_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.entry_valid |->
			out_data.entry_pid == 8'd0 && out_data.entry_frames == 10'd0)
		else $error("free entry with pid or frames");

	// a claimed entry always holds at least one frame
	a_occ_frames: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.entry_valid |-> out_data.entry_frames != 10'd0)
		else $error("occupied entry with no frames");

endmodule

bind round_robin_frame_allocator_unit rrfa_chk u_rrfa_chk (.*);
`default_nettype wire
